### rtl/core/ufic_pkg.sv
// Shared types and codes for the UART FIFO interrupt controller.
// Used by the controller, the datapath and the top level; no dependencies.
package ufic_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RX_INT_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_SIZE   = 2'd2;

    // Item actions
    localparam logic [2:0] ACT_WRITE    = 3'd0;
    localparam logic [2:0] ACT_READ     = 3'd1;
    localparam logic [2:0] ACT_CLEAR_TX = 3'd2;
    localparam logic [2:0] ACT_CLEAR_RX = 3'd3;
    localparam logic [2:0] ACT_EVENT    = 3'd4;
    localparam logic [2:0] ACT_QUERY    = 3'd5;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch the incoming word, launch RAM reads
        logic exec;     // run the item, load the result registers
        logic pop2;     // take the second transmit byte
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_pop2;
    } t_dp_status;

endpackage

### rtl/core/ufic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ufic_ctrl.sv
// Sequencer for the UART FIFO interrupt controller: accept, execute,
// optional second pop, and the output valid flag. Depends on ufic_pkg.
module ufic_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  ufic_pkg::t_dp_status  i_status,
    output ufic_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_POP2 = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   load_out;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        load_out     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register can take the result
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.need_pop2) begin
                        n_state = S_POP2;
                    end else begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_POP2: begin
                o_cmd.pop2 = 1'b1;
                load_out   = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = load_out ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

### rtl/core/ufic_datapath.sv
// Datapath: ring pointers, levels, interrupt enables, configuration and
// result registers around the two FIFO RAMs. Depends on ufic_pkg, ufic_ram.
module ufic_datapath #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ufic_pkg::t_ctrl_cmd            i_cmd,
    output ufic_pkg::t_dp_status           o_status,
    input  logic                           i_cfg_we,
    input  logic [ufic_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ufic_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [2:0]                     i_action,
    input  logic [7:0]                     i_write_byte,
    input  logic                           i_last_of_buffer,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_flag_rx_full,
    input  logic                           i_flag_tx_empty,
    input  logic                           i_flag_tx_done,
    output logic                           o_accepted,
    output logic [7:0]                     o_read_data,
    output logic                           o_tx_fifo_empty,
    output logic                           o_rx_notify,
    output logic                           o_rx_overflow,
    output logic [1:0]                     o_tx_bytes_out,
    output logic [7:0]                     o_tx_byte_first,
    output logic [7:0]                     o_tx_byte_second,
    output logic                           o_send_done,
    output logic                           o_empty_int_enabled,
    output logic                           o_done_int_enabled
);

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int TLW = $clog2(TX_DEPTH + 1);
    localparam int RPW = $clog2(RX_DEPTH);
    localparam int RLW = $clog2(RX_DEPTH + 1);
    localparam int DW  = ufic_pkg::CFG_DATA_W;
    localparam int TCW = (TLW > DW) ? TLW : DW;
    localparam int RCW = (RLW > DW) ? RLW : DW;

    // configuration
    logic          r_rx_int_en;
    logic [DW-1:0] r_tx_size;
    logic [DW-1:0] r_rx_size;

    // latched word
    logic [2:0] r_act;
    logic [7:0] r_wbyte;
    logic       r_last;
    logic [7:0] r_rxbyte;
    logic       r_frx, r_fte, r_ftd;

    // FIFO state
    logic [TPW-1:0] r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic [TLW-1:0] r_tx_level, n_tx_level;
    logic [RPW-1:0] r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [RLW-1:0] r_rx_level, n_rx_level;
    logic           r_empty_en, n_empty_en, r_done_en, n_done_en;

    // results
    logic       r_acc, n_acc;
    logic [7:0] r_rdata, n_rdata;
    logic       r_txe, n_txe;
    logic       r_notify, n_notify;
    logic       r_ovf, n_ovf;
    logic [1:0] r_nout, n_nout;
    logic [7:0] r_b1, n_b1, r_b2, n_b2;
    logic       r_done, n_done;
    logic       r_eie, n_eie, r_die, n_die;

    // effective sizes and pointer advances
    logic [TCW-1:0] tx_size_ext;
    logic [RCW-1:0] rx_size_ext;
    logic [TLW-1:0] tsz;
    logic [RLW-1:0] rsz;
    logic [TPW:0]   tx_wr_inc, tx_rd_inc;
    logic [RPW:0]   rx_wr_inc, rx_rd_inc;
    logic [TPW-1:0] tx_wr_adv, tx_rd_adv;
    logic [RPW-1:0] rx_wr_adv, rx_rd_adv;

    // RAM ports
    logic       tx_we, tx_re, rx_we, rx_re;
    logic [7:0] tx_rdata, rx_rdata;

    // event scratch
    logic ev_e, ev_d, pop1, need_pop2;

    assign tx_size_ext = TCW'(r_tx_size);
    assign rx_size_ext = RCW'(r_rx_size);

    // clamp the size registers to 1..depth
    always_comb begin
        if (tx_size_ext == '0) begin
            tsz = TLW'(1);
        end else if (tx_size_ext > TCW'(TX_DEPTH)) begin
            tsz = TLW'(TX_DEPTH);
        end else begin
            tsz = TLW'(tx_size_ext);
        end
        if (rx_size_ext == '0) begin
            rsz = RLW'(1);
        end else if (rx_size_ext > RCW'(RX_DEPTH)) begin
            rsz = RLW'(RX_DEPTH);
        end else begin
            rsz = RLW'(rx_size_ext);
        end
    end

    assign tx_wr_inc = {1'b0, r_tx_wr} + (TPW+1)'(1);
    assign tx_rd_inc = {1'b0, r_tx_rd} + (TPW+1)'(1);
    assign rx_wr_inc = {1'b0, r_rx_wr} + (RPW+1)'(1);
    assign rx_rd_inc = {1'b0, r_rx_rd} + (RPW+1)'(1);

    assign tx_wr_adv = (tx_wr_inc >= (TPW+1)'(tsz)) ? '0 : tx_wr_inc[TPW-1:0];
    assign tx_rd_adv = (tx_rd_inc >= (TPW+1)'(tsz)) ? '0 : tx_rd_inc[TPW-1:0];
    assign rx_wr_adv = (rx_wr_inc >= (RPW+1)'(rsz)) ? '0 : rx_wr_inc[RPW-1:0];
    assign rx_rd_adv = (rx_rd_inc >= (RPW+1)'(rsz)) ? '0 : rx_rd_inc[RPW-1:0];

    always_comb begin
        n_tx_wr    = r_tx_wr;
        n_tx_rd    = r_tx_rd;
        n_tx_level = r_tx_level;
        n_rx_wr    = r_rx_wr;
        n_rx_rd    = r_rx_rd;
        n_rx_level = r_rx_level;
        n_empty_en = r_empty_en;
        n_done_en  = r_done_en;
        n_acc      = r_acc;
        n_rdata    = r_rdata;
        n_txe      = r_txe;
        n_notify   = r_notify;
        n_ovf      = r_ovf;
        n_nout     = r_nout;
        n_b1       = r_b1;
        n_b2       = r_b2;
        n_done     = r_done;
        n_eie      = r_eie;
        n_die      = r_die;
        tx_we      = 1'b0;
        rx_we      = 1'b0;
        ev_e       = r_empty_en;
        ev_d       = r_done_en;
        pop1       = 1'b0;
        need_pop2  = 1'b0;

        if (i_cmd.exec) begin
            n_acc    = 1'b0;
            n_rdata  = '0;
            n_notify = 1'b0;
            n_ovf    = 1'b0;
            n_nout   = 2'd0;
            n_b1     = '0;
            n_b2     = '0;
            n_done   = 1'b0;
            case (r_act)
                ufic_pkg::ACT_WRITE: begin
                    if (r_tx_level < tsz) begin
                        tx_we      = 1'b1;
                        n_tx_wr    = tx_wr_adv;
                        n_tx_level = r_tx_level + TLW'(1);
                        n_acc      = 1'b1;
                        if (r_last) begin
                            n_done_en = 1'b1;
                        end
                    end else begin
                        n_empty_en = 1'b1;
                    end
                end
                ufic_pkg::ACT_READ: begin
                    if (r_rx_level != '0) begin
                        n_rdata    = rx_rdata;
                        n_rx_rd    = rx_rd_adv;
                        n_rx_level = r_rx_level - RLW'(1);
                        n_acc      = 1'b1;
                    end
                end
                ufic_pkg::ACT_CLEAR_TX: begin
                    n_tx_wr    = '0;
                    n_tx_rd    = '0;
                    n_tx_level = '0;
                end
                ufic_pkg::ACT_CLEAR_RX: begin
                    n_rx_wr    = '0;
                    n_rx_rd    = '0;
                    n_rx_level = '0;
                end
                ufic_pkg::ACT_EVENT: begin
                    // receive stage; drop the oldest byte when full
                    if (r_rx_int_en && r_frx) begin
                        if (r_rx_level >= rsz) begin
                            n_rx_rd = rx_rd_adv;
                            n_ovf   = 1'b1;
                        end else begin
                            n_rx_level = r_rx_level + RLW'(1);
                        end
                        rx_we    = 1'b1;
                        n_rx_wr  = rx_wr_adv;
                        n_notify = 1'b1;
                    end
                    // transmit-empty stage
                    if (ev_e && r_fte) begin
                        if (r_tx_level == '0) begin
                            ev_e = 1'b0;
                            ev_d = 1'b1;
                        end else begin
                            pop1       = 1'b1;
                            n_b1       = tx_rdata;
                            n_tx_rd    = tx_rd_adv;
                            n_tx_level = r_tx_level - TLW'(1);
                            n_nout     = 2'd1;
                        end
                    end
                    // transmit-complete stage sees the level left above
                    if (r_ftd && ev_d) begin
                        if (n_tx_level == '0) begin
                            ev_d   = 1'b0;
                            n_done = 1'b1;
                        end else if (pop1) begin
                            need_pop2 = 1'b1;
                        end else begin
                            n_b1       = tx_rdata;
                            n_tx_rd    = tx_rd_adv;
                            n_tx_level = r_tx_level - TLW'(1);
                            n_nout     = 2'd1;
                        end
                    end
                    n_empty_en = ev_e;
                    n_done_en  = ev_d;
                end
                default: begin
                end
            endcase
            n_txe = (n_tx_level == '0);
            n_eie = n_empty_en;
            n_die = n_done_en;
        end else if (i_cmd.pop2) begin
            n_b2       = tx_rdata;
            n_tx_rd    = tx_rd_adv;
            n_tx_level = r_tx_level - TLW'(1);
            n_nout     = 2'd2;
            n_txe      = (n_tx_level == '0);
        end
    end

    // read at the current pointers on accept; the second pop reads at the
    // pointer left by the first
    assign tx_re = i_cmd.accept || (i_cmd.exec && need_pop2);
    assign rx_re = i_cmd.accept;
    assign o_status.need_pop2 = need_pop2;

    ufic_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (r_wbyte),
        .i_re    (tx_re),
        .i_raddr (n_tx_rd),
        .o_rdata (tx_rdata)
    );

    ufic_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (r_rxbyte),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_int_en <= 1'b1;
            r_tx_size   <= DW'(256);
            r_rx_size   <= DW'(256);
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_tx_level  <= '0;
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_rx_level  <= '0;
            r_empty_en  <= 1'b0;
            r_done_en   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ufic_pkg::CFG_RX_INT_EN: r_rx_int_en <= i_cfg_data[0];
                    ufic_pkg::CFG_TX_SIZE:   r_tx_size   <= i_cfg_data;
                    ufic_pkg::CFG_RX_SIZE:   r_rx_size   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_tx_wr    <= n_tx_wr;
            r_tx_rd    <= n_tx_rd;
            r_tx_level <= n_tx_level;
            r_rx_wr    <= n_rx_wr;
            r_rx_rd    <= n_rx_rd;
            r_rx_level <= n_rx_level;
            r_empty_en <= n_empty_en;
            r_done_en  <= n_done_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act    <= i_action;
            r_wbyte  <= i_write_byte;
            r_last   <= i_last_of_buffer;
            r_rxbyte <= i_rx_byte;
            r_frx    <= i_flag_rx_full;
            r_fte    <= i_flag_tx_empty;
            r_ftd    <= i_flag_tx_done;
        end
        r_acc    <= n_acc;
        r_rdata  <= n_rdata;
        r_txe    <= n_txe;
        r_notify <= n_notify;
        r_ovf    <= n_ovf;
        r_nout   <= n_nout;
        r_b1     <= n_b1;
        r_b2     <= n_b2;
        r_done   <= n_done;
        r_eie    <= n_eie;
        r_die    <= n_die;
    end

    assign o_accepted          = r_acc;
    assign o_read_data         = r_rdata;
    assign o_tx_fifo_empty     = r_txe;
    assign o_rx_notify         = r_notify;
    assign o_rx_overflow       = r_ovf;
    assign o_tx_bytes_out      = r_nout;
    assign o_tx_byte_first     = r_b1;
    assign o_tx_byte_second    = r_b2;
    assign o_send_done         = r_done;
    assign o_empty_int_enabled = r_eie;
    assign o_done_int_enabled  = r_die;

endmodule

### rtl/core/uart_fifo_interrupt_controller_top.sv
// Top level of the UART FIFO interrupt controller.
// Depends on ufic_pkg, ufic_ctrl, ufic_datapath (and ufic_ram through it).
//
// Usage:
//   Input channel (i_valid / o_stall): one word per host access or serial
//   interrupt event: write a byte, read a byte, clear a FIFO, handle an
//   event, or query. Output channel (o_valid / i_stall): exactly one result
//   word per input word, in order.
//   Configuration: pulse i_cfg_we with i_cfg_index / i_cfg_data while the
//   block is idle; index 0 rx interrupt enable, 1 tx size, 2 rx size.
//   Sequence: the word is latched on accept and run in S_EXEC, which loads
//   the result registers; a two-byte event adds S_POP2, as the transmit
//   RAM's single registered read port serializes the second pop. o_stall
//   stays high until the word is done, so the next word waits meanwhile.
//   The output register lets the next word enter while a result waits.
//   Stall: while the receiver stalls, the finished result holds in the
//   output register; the next word is taken but its execution waits until
//   the output register frees up, so nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous): pointers, levels, interrupt enables
//   and the output valid clear; sizes return to 256 and the rx interrupt
//   enable to 1. FIFO RAM contents are left as they are; no clearing pass.
module uart_fifo_interrupt_controller_top #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [2:0]                      i_action,
    input  logic [7:0]                      i_write_byte,
    input  logic                            i_last_of_buffer,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_flag_rx_full,
    input  logic                            i_flag_tx_empty,
    input  logic                            i_flag_tx_done,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [ufic_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ufic_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_accepted,
    output logic [7:0]                      o_read_data,
    output logic                            o_tx_fifo_empty,
    output logic                            o_rx_notify,
    output logic                            o_rx_overflow,
    output logic [1:0]                      o_tx_bytes_out,
    output logic [7:0]                      o_tx_byte_first,
    output logic [7:0]                      o_tx_byte_second,
    output logic                            o_send_done,
    output logic                            o_empty_int_enabled,
    output logic                            o_done_int_enabled
);

    ufic_pkg::t_ctrl_cmd  cmd;
    ufic_pkg::t_dp_status status;

    // sequencer: accept, execute, optional second pop
    ufic_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // FIFOs, enables, configuration and result registers
    ufic_datapath #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_action            (i_action),
        .i_write_byte        (i_write_byte),
        .i_last_of_buffer    (i_last_of_buffer),
        .i_rx_byte           (i_rx_byte),
        .i_flag_rx_full      (i_flag_rx_full),
        .i_flag_tx_empty     (i_flag_tx_empty),
        .i_flag_tx_done      (i_flag_tx_done),
        .o_accepted          (o_accepted),
        .o_read_data         (o_read_data),
        .o_tx_fifo_empty     (o_tx_fifo_empty),
        .o_rx_notify         (o_rx_notify),
        .o_rx_overflow       (o_rx_overflow),
        .o_tx_bytes_out      (o_tx_bytes_out),
        .o_tx_byte_first     (o_tx_byte_first),
        .o_tx_byte_second    (o_tx_byte_second),
        .o_send_done         (o_send_done),
        .o_empty_int_enabled (o_empty_int_enabled),
        .o_done_int_enabled  (o_done_int_enabled)
    );

endmodule

### sim/uart_fifo_interrupt_controller_top_tb.sv
// Self-checking testbench for uart_fifo_interrupt_controller_top.
// Needs ufic_pkg and the controller RTL; predicts every result word in-line and
// compares it field by field under random idle, stall and configuration mixes.
module uart_fifo_interrupt_controller_top_tb;

    // Actions the block treats as a query; the package names only the used ones
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int MEM_DEPTH   = 256;
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int QUIET_LIMIT = 5000;   // cycles with no word moving on either side
    localparam int ITEMS_PER_SETTING = 131;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_byte;
        logic       last_of_buffer;
        logic [7:0] rx_byte;
        logic       flag_rx_full;
        logic       flag_tx_empty;
        logic       flag_tx_done;
    } t_uart_word;

    typedef struct packed {
        logic       accepted;
        logic [7:0] read_data;
        logic       tx_fifo_empty;
        logic       rx_notify;
        logic       rx_overflow;
        logic [1:0] tx_bytes_out;
        logic [7:0] tx_byte_first;
        logic [7:0] tx_byte_second;
        logic       send_done;
        logic       empty_int_enabled;
        logic       done_int_enabled;
    } t_uart_outcome;

    // DUT ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [2:0]                      i_action = ufic_pkg::ACT_QUERY;
    logic [7:0]                      i_write_byte = '0;
    logic                            i_last_of_buffer = 1'b0;
    logic [7:0]                      i_rx_byte = '0;
    logic                            i_flag_rx_full = 1'b0;
    logic                            i_flag_tx_empty = 1'b0;
    logic                            i_flag_tx_done = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [ufic_pkg::CFG_IDX_W-1:0]  i_cfg_index = ufic_pkg::CFG_RX_INT_EN;
    logic [ufic_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_accepted;
    logic [7:0]                      o_read_data;
    logic                            o_tx_fifo_empty;
    logic                            o_rx_notify;
    logic                            o_rx_overflow;
    logic [1:0]                      o_tx_bytes_out;
    logic [7:0]                      o_tx_byte_first;
    logic [7:0]                      o_tx_byte_second;
    logic                            o_send_done;
    logic                            o_empty_int_enabled;
    logic                            o_done_int_enabled;

    // Mirror of the block's FIFOs, enables and registers
    logic [7:0]      tx_mem [MEM_DEPTH];
    logic [7:0]      rx_mem [MEM_DEPTH];
    bit              tx_filled [MEM_DEPTH];   // entry has been written at least once
    bit              rx_filled [MEM_DEPTH];
    int              tx_wp, tx_rp, tx_cnt;
    int              rx_wp, rx_rp, rx_cnt;
    bit              empty_en, done_en;
    bit              rx_int_cfg = 1'b1;
    logic [8:0]      tx_size_cfg = 9'd256;
    logic [8:0]      rx_size_cfg = 9'd256;

    t_uart_outcome   outcomes_due [$];

    int              tx_idle_pct = 0;
    int              rx_stall_pct = 0;
    bit              hold_req = 1'b0;
    bit              hold_on = 1'b0;
    int              err_cnt = 0;
    int              quiet_cycles = 0;
    int              words_sent = 0;
    int              results_checked = 0;
    int              refused_writes = 0;
    int              overflows = 0;
    int              pair_events = 0;
    int              done_pulses = 0;

    uart_fifo_interrupt_controller_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_action            (i_action),
        .i_write_byte        (i_write_byte),
        .i_last_of_buffer    (i_last_of_buffer),
        .i_rx_byte           (i_rx_byte),
        .i_flag_rx_full      (i_flag_rx_full),
        .i_flag_tx_empty     (i_flag_tx_empty),
        .i_flag_tx_done      (i_flag_tx_done),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_accepted          (o_accepted),
        .o_read_data         (o_read_data),
        .o_tx_fifo_empty     (o_tx_fifo_empty),
        .o_rx_notify         (o_rx_notify),
        .o_rx_overflow       (o_rx_overflow),
        .o_tx_bytes_out      (o_tx_bytes_out),
        .o_tx_byte_first     (o_tx_byte_first),
        .o_tx_byte_second    (o_tx_byte_second),
        .o_send_done         (o_send_done),
        .o_empty_int_enabled (o_empty_int_enabled),
        .o_done_int_enabled  (o_done_int_enabled)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Size register as the block uses it: zero reads as one, above depth as depth
    function automatic int clamp_size(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > MEM_DEPTH) return MEM_DEPTH;
        return int'(v);
    endfunction

    // Advance a ring pointer; wrap to zero once it reaches the size in use
    function automatic int step_ptr(input int p, input int size);
        return (p + 1 >= size) ? 0 : p + 1;
    endfunction

    // Pop the oldest transmit byte
    function automatic logic [7:0] tx_take();
        logic [7:0] b;
        b = tx_mem[tx_rp];
        tx_rp = step_ptr(tx_rp, clamp_size(tx_size_cfg));
        tx_cnt--;
        return b;
    endfunction

    // Advance the mirror by one word and return the result it produces
    function automatic t_uart_outcome compute_outcome(input t_uart_word w);
        t_uart_outcome r;
        int            tsz;
        int            rsz;
        int            nout;
        logic [7:0]    b;
        r    = '0;
        nout = 0;
        tsz  = clamp_size(tx_size_cfg);
        rsz  = clamp_size(rx_size_cfg);
        case (w.action)
            ufic_pkg::ACT_WRITE: begin
                if (tx_cnt < tsz) begin
                    tx_mem[tx_wp]    = w.write_byte;
                    tx_filled[tx_wp] = 1'b1;
                    tx_wp            = step_ptr(tx_wp, tsz);
                    tx_cnt++;
                    r.accepted = 1'b1;
                    if (w.last_of_buffer) done_en = 1'b1;
                end else begin
                    // refused write arms the transmit-empty interrupt only
                    empty_en = 1'b1;
                end
            end
            ufic_pkg::ACT_READ: begin
                if (rx_cnt != 0) begin
                    r.read_data = rx_mem[rx_rp];
                    rx_rp       = step_ptr(rx_rp, rsz);
                    rx_cnt--;
                    r.accepted  = 1'b1;
                end
            end
            ufic_pkg::ACT_CLEAR_TX: begin
                tx_wp  = 0;
                tx_rp  = 0;
                tx_cnt = 0;
            end
            ufic_pkg::ACT_CLEAR_RX: begin
                rx_wp  = 0;
                rx_rp  = 0;
                rx_cnt = 0;
            end
            ufic_pkg::ACT_EVENT: begin
                // receive stage: a full FIFO drops its oldest byte
                if (rx_int_cfg && w.flag_rx_full) begin
                    if (rx_cnt >= rsz) begin
                        rx_rp         = step_ptr(rx_rp, rsz);
                        r.rx_overflow = 1'b1;
                    end else begin
                        rx_cnt++;
                    end
                    rx_mem[rx_wp]    = w.rx_byte;
                    rx_filled[rx_wp] = 1'b1;
                    rx_wp            = step_ptr(rx_wp, rsz);
                    r.rx_notify      = 1'b1;
                end
                // transmit-empty stage
                if (empty_en && w.flag_tx_empty) begin
                    if (tx_cnt == 0) begin
                        empty_en = 1'b0;
                        done_en  = 1'b1;
                    end else begin
                        r.tx_byte_first = tx_take();
                        nout++;
                    end
                end
                // transmit-complete stage sees the enable the empty stage left
                if (w.flag_tx_done && done_en) begin
                    if (tx_cnt == 0) begin
                        done_en     = 1'b0;
                        r.send_done = 1'b1;
                    end else begin
                        b = tx_take();
                        if (nout == 0) r.tx_byte_first = b;
                        else r.tx_byte_second = b;
                        nout++;
                    end
                end
            end
            default: ;
        endcase
        r.tx_bytes_out      = nout[1:0];
        r.tx_fifo_empty     = (tx_cnt == 0);
        r.empty_int_enabled = empty_en;
        r.done_int_enabled  = done_en;
        return r;
    endfunction

    // Keep the stimulus off never-written store entries: a read that would land
    // on one becomes a query, an event that would pop one loses its tx flags.
    function automatic t_uart_word make_safe(input t_uart_word w);
        bit ee;
        bit de;
        bit bad;
        int lvl;
        int rp;
        if (w.action == ufic_pkg::ACT_READ && rx_cnt != 0 && !rx_filled[rx_rp]) begin
            w.action = ufic_pkg::ACT_QUERY;
        end
        if (w.action == ufic_pkg::ACT_EVENT) begin
            ee  = empty_en;
            de  = done_en;
            lvl = tx_cnt;
            rp  = tx_rp;
            bad = 1'b0;
            if (ee && w.flag_tx_empty) begin
                if (lvl == 0) begin
                    de = 1'b1;
                end else begin
                    bad = !tx_filled[rp];
                    rp  = step_ptr(rp, clamp_size(tx_size_cfg));
                    lvl--;
                end
            end
            if (w.flag_tx_done && de && lvl != 0 && !tx_filled[rp]) bad = 1'b1;
            if (bad) begin
                w.flag_tx_empty = 1'b0;
                w.flag_tx_done  = 1'b0;
            end
        end
        return w;
    endfunction

    function automatic t_uart_word random_word();
        t_uart_word w;
        int         pick;
        w    = t_uart_word'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 28)      w.action = ufic_pkg::ACT_WRITE;
        else if (pick < 46) w.action = ufic_pkg::ACT_READ;
        else if (pick < 74) w.action = ufic_pkg::ACT_EVENT;
        else if (pick < 79) w.action = ufic_pkg::ACT_CLEAR_TX;
        else if (pick < 84) w.action = ufic_pkg::ACT_CLEAR_RX;
        else if (pick < 92) w.action = ufic_pkg::ACT_QUERY;
        else if (pick < 96) w.action = ACT_SPARE_6;
        else                w.action = ACT_SPARE_7;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Predict, queue the expectation, then offer the word until it is taken
    task automatic send_word(input t_uart_word w);
        t_uart_outcome o;
        w = make_safe(w);
        o = compute_outcome(w);
        outcomes_due.push_back(o);
        words_sent++;
        if (w.action == ufic_pkg::ACT_WRITE && !o.accepted) refused_writes++;
        if (o.rx_overflow) overflows++;
        if (o.tx_bytes_out == 2'd2) pair_events++;
        if (o.send_done) done_pulses++;
        @(negedge i_clk);
        // idle the sender at random before offering the word
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_action         <= w.action;
        i_write_byte     <= w.write_byte;
        i_last_of_buffer <= w.last_of_buffer;
        i_rx_byte        <= w.rx_byte;
        i_flag_rx_full   <= w.flag_rx_full;
        i_flag_tx_empty  <= w.flag_tx_empty;
        i_flag_tx_done   <= w.flag_tx_done;
        // hold the word until the block takes it
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic offer(input logic [2:0] act, input logic [7:0] wb, input bit last,
                         input logic [7:0] rb, input bit frx, input bit fte, input bit ftd);
        send_word('{act, wb, last, rb, frx, fte, ftd});
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (outcomes_due.size() == 0);
    endtask

    task automatic cfg_write(input logic [ufic_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ufic_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            ufic_pkg::CFG_RX_INT_EN: rx_int_cfg  = data[0];
            ufic_pkg::CFG_TX_SIZE:   tx_size_cfg = data;
            ufic_pkg::CFG_RX_SIZE:   rx_size_cfg = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Reprogram all registers once the block has gone quiet; FIFO contents stay
    task automatic apply_setting(input bit rx_int, input logic [8:0] tsz, input logic [8:0] rsz);
        wait_idle();
        cfg_write(ufic_pkg::CFG_RX_INT_EN, {8'd0, rx_int});
        cfg_write(ufic_pkg::CFG_TX_SIZE, tsz);
        cfg_write(ufic_pkg::CFG_RX_SIZE, rsz);
    endtask

    // Mostly single random words, sometimes a whole host buffer followed by
    // the events that drain it
    task automatic run_traffic(input int count);
        int         sent;
        int         room;
        int         len;
        t_uart_word w;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0 && count - sent >= 2) begin
                room = clamp_size(tx_size_cfg) + 2;
                if (room > 40) room = 40;
                if (room > (count - sent) / 2) room = (count - sent) / 2;
                len = $urandom_range(1, room);
                for (int i = 0; i < len; i++) begin
                    w                = random_word();
                    w.action         = ufic_pkg::ACT_WRITE;
                    w.last_of_buffer = (i == len - 1);
                    send_word(w);
                end
                for (int i = 0; i < len; i++) begin
                    w               = random_word();
                    w.action        = ufic_pkg::ACT_EVENT;
                    w.flag_tx_empty = ($urandom_range(3) != 0);
                    w.flag_tx_done  = ($urandom_range(3) != 0);
                    send_word(w);
                end
                sent += 2 * len;
            end else begin
                send_word(random_word());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, hold-off, checker, watchdog
    // ------------------------------------------------------------------

    // Stall the result side at random, or solidly during a hold-off
    always @(negedge i_clk) begin
        i_stall <= hold_on || ($urandom_range(99) < rx_stall_pct);
    end

    // Count out the long hold-off in its own process
    initial begin
        forever begin
            wait (hold_req);
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on  = 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // Check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_uart_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcomes_due.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                err_cnt++;
            end else begin
                want = outcomes_due.pop_front();
                results_checked++;
                compare_field("accepted", want.accepted, o_accepted);
                compare_field("read_data", want.read_data, o_read_data);
                compare_field("tx_fifo_empty", want.tx_fifo_empty, o_tx_fifo_empty);
                compare_field("rx_notify", want.rx_notify, o_rx_notify);
                compare_field("rx_overflow", want.rx_overflow, o_rx_overflow);
                compare_field("tx_bytes_out", want.tx_bytes_out, o_tx_bytes_out);
                compare_field("tx_byte_first", want.tx_byte_first, o_tx_byte_first);
                compare_field("tx_byte_second", want.tx_byte_second, o_tx_byte_second);
                compare_field("send_done", want.send_done, o_send_done);
                compare_field("empty_int_enabled", want.empty_int_enabled,
                              o_empty_int_enabled);
                compare_field("done_int_enabled", want.done_int_enabled, o_done_int_enabled);
            end
        end
    end

    // End the run if no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, outcomes_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two-entry FIFOs make full, overflow and wrap reachable in a few words
    task automatic test_directed();
        apply_setting(1'b1, 9'd2, 9'd2);
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);  // read of empty rx
        offer(ufic_pkg::ACT_QUERY, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
        offer(ufic_pkg::ACT_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_WRITE, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);  // last arms done
        offer(ufic_pkg::ACT_WRITE, 8'hA5, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);  // full: refused
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1);  // two bytes out
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1);  // empty: done
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'h5A, 1'b1, 1'b0, 1'b0);  // rx overflow
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_WRITE, 8'h3C, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_CLEAR_TX, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_QUERY, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'h81, 1'b1, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_CLEAR_RX, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        offer(ACT_SPARE_6, 8'h55, 1'b1, 8'hAA, 1'b1, 1'b1, 1'b1);
        offer(ACT_SPARE_7, 8'hAA, 1'b0, 8'h55, 1'b1, 1'b1, 1'b1);
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);  // no flags
        // receive interrupt off: the event stores nothing
        apply_setting(1'b0, 9'd2, 9'd2);
        offer(ufic_pkg::ACT_EVENT, 8'h00, 1'b0, 8'hC3, 1'b1, 1'b0, 1'b0);
        offer(ufic_pkg::ACT_READ,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // Sweep idle mixes against register settings, extremes included; sizes change
    // with data still held
    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            for (int s = 0; s < 2; s++) begin
                case (ph * 2 + s)
                    0: apply_setting(1'b1, 9'd256, 9'd256);
                    1: apply_setting(1'b1, 9'd1,   9'd1);
                    2: apply_setting(1'b0, 9'd0,   9'd0);
                    3: apply_setting(1'b1, 9'd511, 9'd3);
                    4: apply_setting(1'b1, 9'd4,   9'd300);
                    5: apply_setting(1'b0, 9'd17,  9'd2);
                    6: apply_setting(1'b1, 9'd2,   9'd9);
                    default: apply_setting(1'b1, 9'd256, 9'd256);
                endcase
                run_traffic(ITEMS_PER_SETTING);
            end
        end
    endtask

    // Hold off the receiver while words keep coming so the input backs up
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        apply_setting(1'b1, 9'd8, 9'd8);
        hold_req = 1'b1;
        run_traffic(40);
        wait_idle();
    endtask

    // Pause the sender until every result is back, then resume
    task automatic test_drain_pause();
        tx_idle_pct  = 31;
        rx_stall_pct = 31;
        run_traffic(20);
        wait_idle();
        run_traffic(20);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words over 8 register settings and 4 idle mixes;",
                 words_sent);
        $display("%0d results checked, %0d refused writes, %0d rx overflows, %0d two-byte %s",
                 results_checked, refused_writes, overflows, pair_events, "events");
        $display("and %0d send-done pulses.", done_pulses);
        if (err_cnt == 0 && outcomes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
